[rtl/core/unc_pkg.sv]
// ============================================================================
// Unit normal compressor package
// Shared constants, payload types and the stage record of the divider chain.
// ============================================================================
`default_nettype none

package unc_pkg;

    // Width of one signed input component.
    localparam int COMP_WIDTH = 16;
    // Width of the sum of three magnitudes.
    localparam int SUM_W      = COMP_WIDTH + 2;
    // Width of one projected index before folding.
    localparam int QUO_W      = 7;
    // Left shift that aligns the divisor with the top quotient bit.
    localparam int DIV_SHIFT  = QUO_W - 1;
    // Width of a partial remainder; it stays below twice the aligned divisor.
    localparam int REM_W      = COMP_WIDTH + QUO_W + 1;
    // Number of division cells, one per quotient bit.
    localparam int NUM_CELLS  = QUO_W;
    // Width of the packed result code.
    localparam int CODE_W     = 16;
    // Width of the folded x index field.
    localparam int XIDX_W     = 6;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] comp_x;
        logic signed [COMP_WIDTH-1:0] comp_y;
        logic signed [COMP_WIDTH-1:0] comp_z;
    } t_in;

    typedef struct packed {
        logic [CODE_W-1:0] packed_code;
        logic              zero_input;
    } t_out;

    // Record handed from one division cell to the next.
    typedef struct packed {
        logic             valid;
        logic [2:0]       signs;
        logic             zero;
        logic [REM_W-1:0] divisor;
        logic [REM_W-1:0] rem_x;
        logic [REM_W-1:0] rem_y;
        logic [QUO_W-1:0] quo_x;
        logic [QUO_W-1:0] quo_y;
    } t_stage;

endpackage

`default_nettype wire

[rtl/core/unc_front.sv]
// ============================================================================
// Unit normal compressor front stage
// Takes signed components, forms magnitudes and signs, the scaled dividends and the divisor.
// ============================================================================
`default_nettype none

module unc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire unc_pkg::t_in    i_in,
    output unc_pkg::t_stage      o_stage
);

    logic [unc_pkg::COMP_WIDTH-1:0] w_mag_x;
    logic [unc_pkg::COMP_WIDTH-1:0] w_mag_y;
    logic [unc_pkg::COMP_WIDTH-1:0] w_mag_z;
    logic [unc_pkg::SUM_W-1:0]      w_sum;
    logic [unc_pkg::REM_W-1:0]      w_ext_x;
    logic [unc_pkg::REM_W-1:0]      w_ext_y;
    logic                           r_valid;
    logic                           n_valid;
    unc_pkg::t_stage                r_data;
    unc_pkg::t_stage                n_data;

    // Two's complement negation in the unsigned domain is exact for the
    // most negative value as well.
    assign w_mag_x = i_in.comp_x[unc_pkg::COMP_WIDTH-1] ? (~i_in.comp_x + 1'b1) : i_in.comp_x;
    assign w_mag_y = i_in.comp_y[unc_pkg::COMP_WIDTH-1] ? (~i_in.comp_y + 1'b1) : i_in.comp_y;
    assign w_mag_z = i_in.comp_z[unc_pkg::COMP_WIDTH-1] ? (~i_in.comp_z + 1'b1) : i_in.comp_z;

    assign w_sum = unc_pkg::SUM_W'(w_mag_x) + unc_pkg::SUM_W'(w_mag_y)
                 + unc_pkg::SUM_W'(w_mag_z);

    assign w_ext_x = unc_pkg::REM_W'(w_mag_x);
    assign w_ext_y = unc_pkg::REM_W'(w_mag_y);

    always_comb begin
        n_valid         = i_accept;
        n_data.valid    = i_accept;
        n_data.signs    = {i_in.comp_x[unc_pkg::COMP_WIDTH-1],
                           i_in.comp_y[unc_pkg::COMP_WIDTH-1],
                           i_in.comp_z[unc_pkg::COMP_WIDTH-1]};
        n_data.zero     = (w_sum == '0);
        n_data.divisor  = unc_pkg::REM_W'(w_sum) << unc_pkg::DIV_SHIFT;
        // The scale of 126 is 128 minus 2.
        n_data.rem_x    = (w_ext_x << 7) - (w_ext_x << 1);
        n_data.rem_y    = (w_ext_y << 7) - (w_ext_y << 1);
        n_data.quo_x    = '0;
        n_data.quo_y    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_comb begin
        o_stage       = r_data;
        o_stage.valid = r_valid;
    end

endmodule

`default_nettype wire

[rtl/core/unc_cell.sv]
// ============================================================================
// Unit normal compressor division cell
// Resolves one quotient bit of both projected indices per cycle.
// ============================================================================
`default_nettype none

module unc_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire unc_pkg::t_stage i_stage,
    output unc_pkg::t_stage      o_stage
);

    logic                      w_ge_x;
    logic                      w_ge_y;
    logic [unc_pkg::REM_W-1:0] w_diff_x;
    logic [unc_pkg::REM_W-1:0] w_diff_y;
    logic                      r_valid;
    logic                      n_valid;
    unc_pkg::t_stage           r_data;
    unc_pkg::t_stage           n_data;

    assign w_ge_x   = (i_stage.rem_x >= i_stage.divisor);
    assign w_ge_y   = (i_stage.rem_y >= i_stage.divisor);
    assign w_diff_x = w_ge_x ? (i_stage.rem_x - i_stage.divisor) : i_stage.rem_x;
    assign w_diff_y = w_ge_y ? (i_stage.rem_y - i_stage.divisor) : i_stage.rem_y;

    always_comb begin
        n_valid       = i_stage.valid;
        n_data        = i_stage;
        // The remainder is now below the aligned divisor, so the shift
        // cannot overflow.
        n_data.rem_x  = {w_diff_x[unc_pkg::REM_W-2:0], 1'b0};
        n_data.rem_y  = {w_diff_y[unc_pkg::REM_W-2:0], 1'b0};
        n_data.quo_x  = {i_stage.quo_x[unc_pkg::QUO_W-2:0], w_ge_x};
        n_data.quo_y  = {i_stage.quo_y[unc_pkg::QUO_W-2:0], w_ge_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_comb begin
        o_stage       = r_data;
        o_stage.valid = r_valid;
    end

endmodule

`default_nettype wire

[rtl/core/unit_normal_compress_16bit.sv]
// ============================================================================
// Unit normal compressor, 16-bit octant projection code
// Pipelined top level: front stage, a chain of division cells, output stage.
// ============================================================================
//
// Usage:
//   A direction vector is presented on i_in (three signed components) with
//   i_start high; the transfer happens at the rising edge where i_start is
//   high and o_busy is low. o_busy is always low, so a new vector may be
//   started in every cycle.
//   Each vector produces exactly one result on o_out, shown for a single
//   cycle with o_valid high. The receiver cannot hold results off; results
//   come out in the order the vectors went in.
//   From the accepting edge to the edge that takes the result, the front
//   stage forms magnitudes, the sum and the scaled dividends, the chain of
//   division cells settles the quotient bits (each cell settles one bit of
//   both 7-bit indices), and the output stage folds, packs and registers
//   the code. Throughput is one vector per cycle.
//   An all-zero vector yields code 0 with zero_input set.
//   Reset (synchronous, active low) clears all valid flags in the chain, so
//   vectors in flight are dropped and no result appears until new vectors
//   are started.
// ============================================================================
`default_nettype none

module unit_normal_compress_16bit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire unc_pkg::t_in  i_in,
    output logic               o_busy,
    output logic               o_valid,
    output unc_pkg::t_out      o_out
);

    // Stage records along the chain; entry 0 comes from the front stage.
    unc_pkg::t_stage w_stage [0:unc_pkg::NUM_CELLS];

    logic                             w_accept;
    logic                             w_fold;
    logic [unc_pkg::QUO_W-1:0]        w_xi;
    logic [unc_pkg::QUO_W-1:0]        w_yi;
    logic                             r_valid;
    logic                             n_valid;
    unc_pkg::t_out                    r_out;
    unc_pkg::t_out                    n_out;

    // The pipeline never stalls, so it can always take a new transfer.
    assign o_busy   = 1'b0;
    assign w_accept = i_start & ~o_busy;

    unc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_in     (i_in),
        .o_stage  (w_stage[0])
    );

    // Each cell resolves the next lower quotient bit of both indices.
    for (genvar g = 0; g < unc_pkg::NUM_CELLS; g++) begin : g_cell
        unc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    // Fold the upper half of the x range back: 127 minus a 7-bit value is
    // its bitwise complement.
    assign w_fold = w_stage[unc_pkg::NUM_CELLS].quo_x[unc_pkg::QUO_W-1];
    assign w_xi   = w_fold ? ~w_stage[unc_pkg::NUM_CELLS].quo_x
                           : w_stage[unc_pkg::NUM_CELLS].quo_x;
    assign w_yi   = w_fold ? ~w_stage[unc_pkg::NUM_CELLS].quo_y
                           : w_stage[unc_pkg::NUM_CELLS].quo_y;

    always_comb begin
        n_valid = w_stage[unc_pkg::NUM_CELLS].valid;
        if (w_stage[unc_pkg::NUM_CELLS].zero) begin
            // A zero vector has no direction; the code is forced to zero.
            n_out.packed_code = '0;
            n_out.zero_input  = 1'b1;
        end else begin
            n_out.packed_code = {w_stage[unc_pkg::NUM_CELLS].signs,
                                 w_xi[unc_pkg::XIDX_W-1:0], w_yi};
            n_out.zero_input  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

`ifndef SYNTHESIS
    // Every accepted vector produces its result after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##9 o_valid)
        else $error("result missing nine cycles after a transfer");

    // No result without a vector started at the matching earlier edge.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 9))
        else $error("result without a matching transfer");

    // The zero flag tracks the vector that produced the result.
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.zero_input ==
                     (($past(i_in.comp_x, 9) == '0) && ($past(i_in.comp_y, 9) == '0)
                      && ($past(i_in.comp_z, 9) == '0))))
        else $error("zero flag does not match the input vector");

    // A zero vector carries an all-zero code.
    a_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.zero_input) |-> (o_out.packed_code == '0))
        else $error("zero vector produced a nonzero code");
`endif

endmodule

`default_nettype wire

[sim/unit_normal_compress_16bit_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// Testbench for the 16-bit unit normal compressor
// Sends direction vectors through the command interface and checks each
// packed octant code against a predictor that works in exact integers.
// ============================================================================

module unit_normal_compress_16bit_tb;

    // Projection scale and the fold point of the x index.
    localparam int unsigned PROJ_SCALE = 126;
    localparam int unsigned FOLD_LIMIT = 64;
    localparam int unsigned FOLD_BASE  = 127;

    // Pipeline depth from the accepting edge to the result edge.
    localparam int LATENCY_CYCLES = 9;
    localparam int DRAIN_LIMIT    = 2000;

    // Random vector counts for the gapped phase and the closing stream.
    localparam int GAPPED_VECTORS = 1050;
    localparam int STREAM_VECTORS = 300;

    // Random component classes.
    typedef enum int {
        COMP_FULL,
        COMP_SMALL,
        COMP_EXTREME,
        COMP_ZERO
    } t_comp_kind;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_start;
    unc_pkg::t_in   i_in;
    logic           o_busy;
    logic           o_valid;
    unc_pkg::t_out  o_out;

    // Expected codes in the order their vectors were transferred.
    unc_pkg::t_out  expected_codes[$];

    int    vectors_sent;
    int    codes_checked;
    int    zero_codes_seen;
    int    folded_sent;
    int    error_count;

    unit_normal_compress_16bit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    // 10 ns clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Magnitude of one signed component. The most negative value maps to
    // 2^(COMP_WIDTH-1); the subtraction from 2^COMP_WIDTH needs the extra top bit.
    function automatic logic [unc_pkg::COMP_WIDTH:0] component_magnitude(
        logic [unc_pkg::COMP_WIDTH-1:0] raw
    );
        if (raw[unc_pkg::COMP_WIDTH-1]) begin
            return ({1'b1, {unc_pkg::COMP_WIDTH{1'b0}}}) - {1'b0, raw};
        end
        return {1'b0, raw};
    endfunction

    // Octant projection code of one vector, computed with truncating
    // integer division exactly as the hardware must.
    function automatic unc_pkg::t_out project_octant_code(unc_pkg::t_in v);
        logic [unc_pkg::COMP_WIDTH:0] mag_x;
        logic [unc_pkg::COMP_WIDTH:0] mag_y;
        logic [unc_pkg::COMP_WIDTH:0] mag_z;
        int unsigned                  total;
        int unsigned                  idx_x;
        int unsigned                  idx_y;
        unc_pkg::t_out                r;
        mag_x = component_magnitude(v.comp_x);
        mag_y = component_magnitude(v.comp_y);
        mag_z = component_magnitude(v.comp_z);
        total = mag_x + mag_y + mag_z;
        r = '0;
        if (total == 0) begin
            r.zero_input = 1'b1;
            return r;
        end
        idx_x = (PROJ_SCALE * mag_x) / total;
        idx_y = (PROJ_SCALE * mag_y) / total;
        if (idx_x >= FOLD_LIMIT) begin
            idx_x = FOLD_BASE - idx_x;
            idx_y = FOLD_BASE - idx_y;
        end
        r.packed_code = {v.comp_x[unc_pkg::COMP_WIDTH-1], v.comp_y[unc_pkg::COMP_WIDTH-1],
                         v.comp_z[unc_pkg::COMP_WIDTH-1], idx_x[unc_pkg::XIDX_W-1:0],
                         idx_y[6:0]};
        return r;
    endfunction

    function automatic unc_pkg::t_in make_vector(logic [unc_pkg::COMP_WIDTH-1:0] x,
                                                 logic [unc_pkg::COMP_WIDTH-1:0] y,
                                                 logic [unc_pkg::COMP_WIDTH-1:0] z);
        unc_pkg::t_in v;
        v.comp_x = x;
        v.comp_y = y;
        v.comp_z = z;
        return v;
    endfunction

    function automatic logic [unc_pkg::COMP_WIDTH-1:0] random_component(
        t_comp_kind kind
    );
        logic [unc_pkg::COMP_WIDTH-1:0] pick;
        case (kind)
            COMP_SMALL: begin
                pick = unc_pkg::COMP_WIDTH'($urandom_range(0, 16))
                     - unc_pkg::COMP_WIDTH'(8);
            end
            COMP_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       pick = {1'b1, {(unc_pkg::COMP_WIDTH-1){1'b0}}};
                    1:       pick = {1'b0, {(unc_pkg::COMP_WIDTH-1){1'b1}}};
                    2:       pick = '1;
                    3:       pick = unc_pkg::COMP_WIDTH'(1);
                    default: pick = {2'b11, {(unc_pkg::COMP_WIDTH-2){1'b0}}};
                endcase
            end
            COMP_ZERO: begin
                pick = '0;
            end
            default: begin
                pick = unc_pkg::COMP_WIDTH'($urandom);
            end
        endcase
        return pick;
    endfunction

    // Mostly full-range components, mixed with small ones, extremes and
    // zeros so that single-axis vectors, fold boundaries and the all-zero
    // vector keep turning up.
    function automatic t_comp_kind random_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return COMP_FULL;
        if (roll < 70) return COMP_SMALL;
        if (roll < 85) return COMP_EXTREME;
        return COMP_ZERO;
    endfunction

    function automatic unc_pkg::t_in random_vector();
        return make_vector(random_component(random_kind()),
                           random_component(random_kind()),
                           random_component(random_kind()));
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Hold start low for a number of cycles; the data bus carries noise,
    // which the block must ignore.
    task automatic hold_start_low(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            i_in    <= unc_pkg::t_in'({$urandom, $urandom});
        end
    endtask

    // Present one vector and wait for the edge that transfers it. The
    // checker sees the same edge and queues the prediction.
    task automatic send_vector(unc_pkg::t_in v);
        @(negedge i_clk);
        i_start <= 1'b1;
        i_in    <= v;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        vectors_sent++;
        if (!project_octant_code(v).zero_input &&
            (PROJ_SCALE * component_magnitude(v.comp_x)) /
            (component_magnitude(v.comp_x) + component_magnitude(v.comp_y) +
             component_magnitude(v.comp_z)) >= FOLD_LIMIT) begin
            folded_sent++;
        end
    endtask

    // Result checker and transfer monitor. Both run off the pre-edge values
    // at each rising edge, so nothing here depends on event ordering.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("unexpected result code=%h zero=%b",
                                              o_out.packed_code, o_out.zero_input));
                end else begin
                    unc_pkg::t_out want;
                    want = expected_codes.pop_front();
                    codes_checked++;
                    if (o_out.zero_input === 1'b1) zero_codes_seen++;
                    if (o_out.packed_code !== want.packed_code) begin
                        report_mismatch($sformatf("packed_code got %h want %h",
                                                  o_out.packed_code, want.packed_code));
                    end
                    if (o_out.zero_input !== want.zero_input) begin
                        report_mismatch($sformatf("zero_input got %b want %b",
                                                  o_out.zero_input, want.zero_input));
                    end
                end
            end
            if (i_start === 1'b1 && o_busy === 1'b0) begin
                expected_codes.push_back(project_octant_code(i_in));
            end
        end
    end

    // Corners: the all-zero vector, each axis at both extremes, the most
    // negative value on every axis, sign combinations and tiny components.
    task automatic test_corner_vectors();
        send_vector(make_vector(16'h0000, 16'h0000, 16'h0000));
        send_vector(make_vector(16'h7FFF, 16'h0000, 16'h0000));
        send_vector(make_vector(16'h8000, 16'h0000, 16'h0000));
        send_vector(make_vector(16'h0000, 16'h7FFF, 16'h0000));
        send_vector(make_vector(16'h0000, 16'h8000, 16'h0000));
        send_vector(make_vector(16'h0000, 16'h0000, 16'h7FFF));
        send_vector(make_vector(16'h0000, 16'h0000, 16'h8000));
        send_vector(make_vector(16'h8000, 16'h8000, 16'h8000));
        send_vector(make_vector(16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_vector(make_vector(16'h8000, 16'h7FFF, 16'h8000));
        send_vector(make_vector(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_vector(make_vector(16'h0001, 16'h0000, 16'h0000));
        send_vector(make_vector(16'h0000, 16'h0000, 16'h0001));
        send_vector(make_vector(16'hFFFF, 16'h0001, 16'h0000));
        send_vector(make_vector(16'h5A5A, 16'hA5A5, 16'h0F0F));
        send_vector(make_vector(16'h0000, 16'h0000, 16'h0000));
    endtask

    // Around the fold: an x index of exactly 63 stays, 64 folds, and a
    // dominant x folds to a small index with y near its top.
    task automatic test_fold_boundary();
        send_vector(make_vector(16'd63, 16'd0, 16'd63));
        send_vector(make_vector(16'd64, 16'd0, 16'd62));
        send_vector(make_vector(16'hFFC0, 16'd0, 16'hFFC2));
        send_vector(make_vector(16'd64, 16'd62, 16'd0));
        send_vector(make_vector(16'h4000, 16'h3FFF, 16'h0001));
        send_vector(make_vector(16'h7FFF, 16'h0001, 16'h0001));
        send_vector(make_vector(16'h8000, 16'hFFFF, 16'h0000));
    endtask

    // Random vectors, one in six on average preceded by a start gap of random
    // length, leaving long gap-free stretches too.
    task automatic test_random_with_gaps();
        for (int n = 0; n < GAPPED_VECTORS; n++) begin
            if ($urandom_range(0, 5) == 0) hold_start_low($urandom_range(1, 13));
            send_vector(random_vector());
        end
    endtask

    // Closing stream: one vector per cycle, no gaps.
    task automatic test_back_to_back_stream();
        for (int n = 0; n < STREAM_VECTORS; n++) begin
            send_vector(random_vector());
        end
    endtask

    initial begin
        int waited;
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_in            = '0;
        vectors_sent    = 0;
        codes_checked   = 0;
        zero_codes_seen = 0;
        folded_sent     = 0;
        error_count     = 0;

        // Synchronous reset, released away from the edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_vectors();
        test_fold_boundary();
        test_random_with_gaps();
        test_back_to_back_stream();

        @(negedge i_clk);
        i_start <= 1'b0;

        // Let every outstanding code come back, then a little longer so a
        // stray extra result would still be caught.
        waited = 0;
        while (expected_codes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY_CYCLES + 4) @(posedge i_clk);
        if (expected_codes.size() != 0) begin
            report_mismatch($sformatf("%0d expected codes never arrived",
                                      expected_codes.size()));
        end

        $display("Covered %0d vectors (%0d folded), %0d codes checked, %0d all-zero.",
                 vectors_sent, folded_sent, codes_checked, zero_codes_seen);
        $display("Mismatches: %0d.", error_count);
        if (error_count == 0) begin
            $display("PASS unit_normal_compress_16bit");
        end else begin
            $display("FAIL unit_normal_compress_16bit");
        end
        $finish;
    end

    // Watchdog: ends a hung run with a failure.
    initial begin
        #2_000_000;
        $display("FAIL unit_normal_compress_16bit");
        $finish;
    end

endmodule
